FILE: sv/assert_macros.svh
// Assertion macros shared by the GPIO port RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("GPIO port assertion failed");
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("GPIO port assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: sv/gpl_pkg.sv
// Shared constants, register offsets and types of the GPIO port with lock.
// Depends on nothing.
package gpl_pkg;

    localparam int NUM_PINS_DEF = 16;
    localparam int MAX_PINS     = 16;

    localparam logic [31:0] CFG_RESET   = 32'h4444_4444;
    localparam logic [3:0]  NIBBLE_MASK = 4'b1111;
    localparam int          KEY_BIT     = 16;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [2:0] OFF_CFG_LO = 3'd0;
    localparam logic [2:0] OFF_CFG_HI = 3'd1;
    localparam logic [2:0] OFF_INPUT  = 3'd2;
    localparam logic [2:0] OFF_OUTPUT = 3'd3;
    localparam logic [2:0] OFF_SETRST = 3'd4;
    localparam logic [2:0] OFF_LOCK   = 3'd6;

    typedef struct packed {
        logic        func;
        logic [2:0]  reg_offset;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } t_access;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic        port_locked;
    } t_result;

    typedef struct packed {
        logic    en;
        t_access acc;
    } t_core_req;

endpackage

FILE: sv/gpl_if.sv
// Valid/ready channel interfaces for bus access words and result words.
// Depends on nothing.
interface gpl_access_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [2:0]  reg_offset;
    logic [31:0] write_data;
    logic [15:0] pin_levels;

    modport source (output valid, func, reg_offset, write_data, pin_levels, input ready);
    modport sink   (input valid, func, reg_offset, write_data, pin_levels, output ready);
endinterface

interface gpl_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [15:0] pin_drive;
    logic        port_locked;

    modport source (output valid, read_data, pin_drive, port_locked, input ready);
    modport sink   (input valid, read_data, pin_drive, port_locked, output ready);
endinterface

FILE: sv/gpl_core.sv
// Register file of the port: configuration words, output latch and lock logic.
// Depends on gpl_pkg.
module gpl_core #(
    parameter int NUM_PINS = gpl_pkg::NUM_PINS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gpl_pkg::t_core_req  i_req,
    output gpl_pkg::t_result    o_res
);

    localparam logic [15:0] PinMask = 16'((33'd1 << NUM_PINS) - 33'd1);

    // Lock key sequence steps.
    localparam logic [2:0] LK_IDLE  = 3'd0;
    localparam logic [2:0] LK_WR1   = 3'd1;
    localparam logic [2:0] LK_WR0   = 3'd2;
    localparam logic [2:0] LK_WR1B  = 3'd3;
    localparam logic [2:0] LK_READ1 = 3'd4;

    logic [31:0] r_cfg [2];
    logic [31:0] n_cfg [2];
    logic [15:0] r_latch, n_latch;
    logic [15:0] r_lpins, n_lpins;
    logic        r_key, n_key;
    logic [2:0]  r_step, n_step;

    logic [63:0] w_frozen;
    logic [31:0] w_fz;
    logic [31:0] w_rd;
    logic [15:0] w_pins;
    logic [15:0] w_clr;
    logic        w_keybit;
    logic        w_same;

    always_comb begin
        for (int p = 0; p < gpl_pkg::MAX_PINS; p++) begin
            w_frozen[p*4 +: 4] = ((p >= NUM_PINS) || (r_key && r_lpins[p]))
                               ? gpl_pkg::NIBBLE_MASK : 4'b0000;
        end
    end

    assign w_fz     = i_req.acc.reg_offset[0] ? w_frozen[63:32] : w_frozen[31:0];
    assign w_pins   = i_req.acc.write_data[15:0] & PinMask;
    assign w_clr    = i_req.acc.write_data[31:16] & PinMask;
    assign w_keybit = i_req.acc.write_data[gpl_pkg::KEY_BIT];
    assign w_same   = (w_pins == r_lpins);

    always_comb begin
        n_cfg   = r_cfg;
        n_latch = r_latch;
        n_lpins = r_lpins;
        n_key   = r_key;
        n_step  = r_step;
        w_rd    = '0;
        if (i_req.acc.func == gpl_pkg::FUNC_WRITE) begin
            case (i_req.acc.reg_offset)
                gpl_pkg::OFF_CFG_LO, gpl_pkg::OFF_CFG_HI: begin
                    n_cfg[i_req.acc.reg_offset[0]] =
                        (r_cfg[i_req.acc.reg_offset[0]] & w_fz)
                        | (i_req.acc.write_data & ~w_fz);
                end
                gpl_pkg::OFF_OUTPUT: begin
                    n_latch = i_req.acc.write_data[15:0] & PinMask;
                end
                gpl_pkg::OFF_SETRST: begin
                    // Set wins over clear for the same pin.
                    n_latch = (r_latch & ~w_clr) | w_pins;
                end
                gpl_pkg::OFF_LOCK: begin
                    if (!r_key) begin
                        if (r_step == LK_WR1 && !w_keybit && w_same) begin
                            n_step = LK_WR0;
                        end else if (r_step == LK_WR0 && w_keybit && w_same) begin
                            n_step = LK_WR1B;
                        end else begin
                            n_step = w_keybit ? LK_WR1 : LK_IDLE;
                        end
                        n_lpins = w_pins;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (i_req.acc.reg_offset)
                gpl_pkg::OFF_CFG_LO, gpl_pkg::OFF_CFG_HI: begin
                    w_rd = r_cfg[i_req.acc.reg_offset[0]];
                end
                gpl_pkg::OFF_INPUT: begin
                    w_rd = {16'd0, i_req.acc.pin_levels & PinMask};
                end
                gpl_pkg::OFF_OUTPUT: begin
                    w_rd = {16'd0, r_latch};
                end
                gpl_pkg::OFF_LOCK: begin
                    if (!r_key) begin
                        if (r_step == LK_WR1B) begin
                            n_step = LK_READ1;
                        end else if (r_step == LK_READ1) begin
                            n_key  = 1'b1;
                            n_step = LK_IDLE;
                        end else begin
                            n_step = LK_IDLE;
                        end
                    end
                    // The second read of the sequence already shows the key.
                    w_rd = {15'd0, n_key, r_lpins};
                end
                default: begin
                    w_rd = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= gpl_pkg::CFG_RESET;
            r_cfg[1] <= gpl_pkg::CFG_RESET;
            r_latch  <= '0;
            r_lpins  <= '0;
            r_key    <= 1'b0;
            r_step   <= LK_IDLE;
        end else if (i_req.en) begin
            r_cfg[0] <= n_cfg[0];
            r_cfg[1] <= n_cfg[1];
            r_latch  <= n_latch;
            r_lpins  <= n_lpins;
            r_key    <= n_key;
            r_step   <= n_step;
        end
    end

    assign o_res.read_data   = w_rd;
    assign o_res.pin_drive   = n_latch;
    assign o_res.port_locked = n_key;

endmodule

FILE: sv/gpio_port_registers_with_lock.sv
// Top level of the GPIO port with lock: access and result channels around the core.
// Depends on gpl_pkg, gpl_if, gpl_core and assert_macros.svh.
//
// Use of the block:
// Each word on i_acc is one bus access: a read or a write of one register offset
// (configuration low and high, input data, output data, set/reset, lock), with
// the sampled pin levels travelling alongside. Each accepted word produces
// exactly one word on o_res: the read data (zero for writes and write-only or
// reserved offsets), the output latch after the access, and the lock flag.
// A word taken at one clock edge sits in the input register, is evaluated by
// the core and moves into the result register once that register is free or
// draining. The throughput is one access per cycle while the receiver does not
// stall, set by the single pass through the core's register update.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more access; i_acc.ready falls only when both are
// full. Reset clears both stages and returns the port to floating inputs, a
// zero output latch and an unlocked lock register; a completed lock key
// sequence can only be undone by reset.
`include "assert_macros.svh"

module gpio_port_registers_with_lock #(
    parameter int NUM_PINS = gpl_pkg::NUM_PINS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gpl_access_if.sink         i_acc,
    gpl_result_if.source       o_res
);

    localparam logic [15:0] PinMask = 16'((33'd1 << NUM_PINS) - 33'd1);

    logic               r_in_valid;
    gpl_pkg::t_access   r_acc;
    logic               r_out_valid;
    gpl_pkg::t_result   r_out;

    logic               w_in_fire;
    logic               w_advance;
    gpl_pkg::t_core_req w_req;
    gpl_pkg::t_result   w_res;

    // The evaluated word moves on whenever the result register is free or draining.
    assign w_advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_acc.ready  = !r_in_valid || !r_out_valid || o_res.ready;
    assign w_in_fire    = i_acc.valid && i_acc.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_acc.func       <= i_acc.func;
            r_acc.reg_offset <= i_acc.reg_offset;
            r_acc.write_data <= i_acc.write_data;
            r_acc.pin_levels <= i_acc.pin_levels;
        end
    end

    // The core commits its state only when the word leaves the input register.
    assign w_req.en  = w_advance;
    assign w_req.acc = r_acc;

    gpl_core #(
        .NUM_PINS (NUM_PINS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.read_data   = r_out.read_data;
    assign o_res.pin_drive   = r_out.pin_drive;
    assign o_res.port_locked = r_out.port_locked;

    // Once a locked result has been produced, later results stay locked.
    `ASSERT_CLK(a_lock_sticky, i_clk, i_rst_n,
        (r_out_valid && r_out.port_locked) |=> (!r_out_valid || r_out.port_locked))
    // Writes never return read data.
    `ASSERT_CLK(a_write_reads_zero, i_clk, i_rst_n,
        (w_advance && r_acc.func == gpl_pkg::FUNC_WRITE) |-> (w_res.read_data == 32'd0))
    // Absent pins are never driven.
    `ASSERT_CLK(a_absent_undriven, i_clk, i_rst_n,
        w_advance |-> ((w_res.pin_drive & ~PinMask) == 16'd0))
    // A word is never taken while both stages are full and the receiver stalls.
    `ASSERT_CLK(a_no_overrun, i_clk, i_rst_n,
        (r_in_valid && r_out_valid && !o_res.ready) |-> !w_in_fire)

endmodule

FILE: tb/sv/gpl_port_checker.sv
// Scoreboard for the GPIO port with lock: watches the access and result channels,
// predicts every result word and compares it field by field with what the port returns.
// Depends on gpl_pkg and gpl_if.
module gpl_port_checker #(
    parameter int NUM_PINS = gpl_pkg::NUM_PINS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    gpl_access_if  acc,
    gpl_result_if  res,
    output int     o_fail_count,
    output int     o_pending
);

    import gpl_pkg::*;

    typedef enum logic [2:0] {
        KEY_IDLE,
        KEY_FIRST_SET,
        KEY_CLEARED,
        KEY_SECOND_SET,
        KEY_FIRST_READ
    } t_key_step;

    localparam logic [15:0] PIN_MASK =
        (NUM_PINS >= 16) ? 16'hFFFF : 16'((32'd1 << NUM_PINS) - 32'd1);

    logic [31:0] cfg_word [2];
    logic [15:0] out_latch;
    logic [15:0] lock_pins;
    logic        lock_key;
    t_key_step   key_step;

    t_result     expected_q [$];
    int          fail_count   = 0;
    int          results_seen = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_failure(input string what);
        fail_count++;
        $display("gpl check: result word %0d: %s", results_seen, what);
    endtask

    // Nibbles that a configuration write must leave alone: absent pins and locked pins.
    function automatic logic [31:0] frozen_nibbles(input int word);
        logic [31:0] mask;
        int          pin;
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            pin = word * 8 + i;
            if (pin >= NUM_PINS || (lock_key && lock_pins[pin]))
                mask[i*4 +: 4] = NIBBLE_MASK;
        end
        return mask;
    endfunction

    function automatic void key_write(input logic [31:0] data);
        logic [15:0] pins;
        logic        key;
        logic        same;
        pins = data[15:0] & PIN_MASK;
        key  = data[KEY_BIT];
        same = (pins == lock_pins);
        if (!lock_key) begin
            if (key_step == KEY_FIRST_SET && !key && same)
                key_step = KEY_CLEARED;
            else if (key_step == KEY_CLEARED && key && same)
                key_step = KEY_SECOND_SET;
            else
                key_step = key ? KEY_FIRST_SET : KEY_IDLE;
            lock_pins = pins;
        end
    endfunction

    function automatic logic [31:0] key_read();
        if (!lock_key) begin
            if (key_step == KEY_SECOND_SET) begin
                key_step = KEY_FIRST_READ;
            end else if (key_step == KEY_FIRST_READ) begin
                lock_key = 1'b1;
                key_step = KEY_IDLE;
            end else begin
                key_step = KEY_IDLE;
            end
        end
        return {15'h0, lock_key, lock_pins};
    endfunction

    function automatic t_result port_response(input t_access a);
        t_result     r;
        logic [31:0] fz;
        int          w;
        r = '0;
        w = (a.reg_offset == OFF_CFG_HI) ? 1 : 0;
        if (a.func == FUNC_WRITE) begin
            case (a.reg_offset)
                OFF_CFG_LO, OFF_CFG_HI: begin
                    fz = frozen_nibbles(w);
                    cfg_word[w] = (cfg_word[w] & fz) | (a.write_data & ~fz);
                end
                OFF_OUTPUT: out_latch = a.write_data[15:0] & PIN_MASK;
                // Set bits win over clear bits of the same pin.
                OFF_SETRST: out_latch = ((out_latch & ~(a.write_data[31:16] & PIN_MASK))
                                        | (a.write_data[15:0] & PIN_MASK)) & PIN_MASK;
                OFF_LOCK:   key_write(a.write_data);
                default: ;
            endcase
        end else begin
            case (a.reg_offset)
                OFF_CFG_LO, OFF_CFG_HI: r.read_data = cfg_word[w];
                OFF_INPUT:  r.read_data = {16'h0, a.pin_levels & PIN_MASK};
                OFF_OUTPUT: r.read_data = {16'h0, out_latch};
                OFF_LOCK:   r.read_data = key_read();
                default:    r.read_data = '0;
            endcase
        end
        r.pin_drive   = out_latch;
        r.port_locked = lock_key;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_word[0] = CFG_RESET;
            cfg_word[1] = CFG_RESET;
            out_latch   = '0;
            lock_pins   = '0;
            lock_key    = 1'b0;
            key_step    = KEY_IDLE;
            expected_q.delete();
        end else begin
            if (acc.valid && acc.ready)
                expected_q.push_back(port_response(t_access'{
                    func:       acc.func,
                    reg_offset: acc.reg_offset,
                    write_data: acc.write_data,
                    pin_levels: acc.pin_levels}));
            if (res.valid && res.ready) begin
                if (expected_q.size() == 0) begin
                    report_failure("result word with no access outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (res.read_data !== want.read_data)
                        report_failure($sformatf("read_data expected %08h, got %08h",
                                                 want.read_data, res.read_data));
                    if (res.pin_drive !== want.pin_drive)
                        report_failure($sformatf("pin_drive expected %04h, got %04h",
                                                 want.pin_drive, res.pin_drive));
                    if (res.port_locked !== want.port_locked)
                        report_failure($sformatf("port_locked expected %0b, got %0b",
                                                 want.port_locked, res.port_locked));
                end
                results_seen++;
            end
        end
        o_pending    = expected_q.size();
        o_fail_count = fail_count;
    end

endmodule

FILE: tb/sv/tb_gpio_port_registers_with_lock.sv
// Top of the GPIO port testbench: clock, reset, access stimulus and result stalls,
// with the scoreboard beside the port. Depends on gpl_pkg, gpl_if, gpl_port_checker
// and the port RTL.
module tb_gpio_port_registers_with_lock;

    import gpl_pkg::*;

    // Limits of the run. The cycle limit sits several times above the length of
    // the slowest correct run.
    localparam int RUN_LIMIT    = 200000;
    localparam int DIRECTED_CAP = 25;
    localparam int LOCK_POINT   = DIRECTED_CAP + 520;
    localparam int QUIET_START  = DIRECTED_CAP + 750;
    localparam int RUN_END      = DIRECTED_CAP + 900;

    // Shapes of lock key attempt. All but the last break off before the port locks.
    typedef enum int {
        ATT_EARLY_READ,
        ATT_AFTER_CLEAR_READ,
        ATT_PIN_CHANGE,
        ATT_LATE_WRITE,
        ATT_WRITE_AFTER_READ,
        ATT_CLEAR_FIRST,
        ATT_COMPLETE
    } t_attempt;

    // Which lock register accesses random words may carry.
    typedef enum int {
        LOCK_NONE,
        LOCK_WRITES,
        LOCK_ANY
    } t_lock_use;

    logic i_clk;
    logic i_rst_n;

    gpl_access_if acc_ch ();
    gpl_result_if res_ch ();

    int fail_count;
    int pending_words;
    int cycle_count = 0;
    int words_sent  = 0;
    // One in gap_odds words is preceded by an idle burst, one in stall_odds cycles
    // starts a stall burst on the result side; zero means no idling at all.
    int gap_odds    = 3;
    int stall_odds  = 3;

    gpio_port_registers_with_lock u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc_ch),
        .o_res   (res_ch)
    );

    gpl_port_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .acc          (acc_ch),
        .res          (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // A hung handshake or a lost result word ends here.
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("** gpio_port_registers_with_lock: FAILED **");
        $finish;
    end

    // Result side: ready is changed only at falling edges, one assignment per edge.
    // A stall burst holds ready low, and its length is drawn at random.
    initial begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                stall_left   = $urandom_range(1, 15) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_access make_access(input logic func, input logic [2:0] offset,
                                            input logic [31:0] data,
                                            input logic [15:0] levels);
        t_access a;
        a.func       = func;
        a.reg_offset = offset;
        a.write_data = data;
        a.pin_levels = levels;
        return a;
    endfunction

    // Bits above the key bit carry random junk, which the lock register must ignore.
    function automatic t_access make_lock_write(input logic key, input logic [15:0] pins);
        return make_access(FUNC_WRITE, OFF_LOCK, {15'($urandom), key, pins},
                           16'($urandom));
    endfunction

    function automatic t_access make_lock_read();
        return make_access(FUNC_READ, OFF_LOCK, $urandom, 16'($urandom));
    endfunction

    function automatic t_access random_access(input t_lock_use lock_use);
        t_access a;
        a.func       = 1'($urandom_range(0, 1));
        a.reg_offset = 3'($urandom_range(0, 7));
        while (lock_use == LOCK_NONE && a.reg_offset == OFF_LOCK)
            a.reg_offset = 3'($urandom_range(0, 7));
        // Lock reads may only come from a planned attempt until the port is locked,
        // otherwise a stray read could finish the key sequence early.
        if (lock_use == LOCK_WRITES && a.reg_offset == OFF_LOCK)
            a.func = FUNC_WRITE;
        case ($urandom_range(0, 7))
            0:       a.write_data = '1;
            1:       a.write_data = '0;
            default: a.write_data = $urandom;
        endcase
        a.pin_levels = 16'($urandom);
        return a;
    endfunction

    function automatic int idle_odds_pick();
        int k;
        k = $urandom_range(0, 3);
        return (k == 0) ? 0 : (1 << k);
    endfunction

    // Offers one word on the access channel and returns just after the edge that
    // takes it. Valid stays high from one word to the next unless an idle burst
    // is drawn, so back-to-back words and gaps both occur.
    task automatic send_word(input t_access a);
        @(negedge i_clk);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            acc_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        acc_ch.valid      <= 1'b1;
        acc_ch.func       <= a.func;
        acc_ch.reg_offset <= a.reg_offset;
        acc_ch.write_data <= a.write_data;
        acc_ch.pin_levels <= a.pin_levels;
        do @(posedge i_clk); while (!acc_ch.ready);
        words_sent++;
    endtask

    // One try at the lock key sequence. Accesses to other registers are slipped in
    // between the steps now and then, since they must not disturb the sequence.
    task automatic drive_key_attempt(input t_attempt shape);
        t_access     steps [$];
        logic [15:0] pins;
        logic [15:0] other;
        pins  = 16'($urandom);
        other = pins ^ 16'($urandom_range(1, 16'hFFFF));
        if (shape == ATT_CLEAR_FIRST) begin
            // Starting with the key bit clear leaves the sequence idle.
            steps.push_back(make_lock_write(1'b0, pins));
            steps.push_back(make_lock_write(1'b0, pins));
            steps.push_back(make_lock_write(1'b1, pins));
        end else begin
            steps.push_back(make_lock_write(1'b1, pins));
            case (shape)
                ATT_EARLY_READ: begin
                    steps.push_back(make_lock_read());
                end
                ATT_AFTER_CLEAR_READ: begin
                    steps.push_back(make_lock_write(1'b0, pins));
                    steps.push_back(make_lock_read());
                end
                ATT_PIN_CHANGE: begin
                    steps.push_back(make_lock_write(1'b0, other));
                    steps.push_back(make_lock_write(1'b1, other));
                end
                ATT_LATE_WRITE: begin
                    steps.push_back(make_lock_write(1'b0, pins));
                    steps.push_back(make_lock_write(1'b1, pins));
                    steps.push_back(make_lock_write(1'($urandom_range(0, 1)), pins));
                end
                ATT_WRITE_AFTER_READ: begin
                    steps.push_back(make_lock_write(1'b0, pins));
                    steps.push_back(make_lock_write(1'b1, pins));
                    steps.push_back(make_lock_read());
                    steps.push_back(make_lock_write(1'($urandom_range(0, 1)), other));
                end
                ATT_COMPLETE: begin
                    steps.push_back(make_lock_write(1'b0, pins));
                    steps.push_back(make_lock_write(1'b1, pins));
                    steps.push_back(make_lock_read());
                    steps.push_back(make_lock_read());
                end
                default: ;
            endcase
        end
        foreach (steps[i]) begin
            send_word(steps[i]);
            if (i < steps.size() - 1 && $urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 2)) send_word(random_access(LOCK_NONE));
        end
    endtask

    initial begin
        t_access directed_q [$];
        int      next_shuffle;
        bit      port_locked_done;

        i_rst_n           = 1'b0;
        acc_ch.valid      = 1'b0;
        acc_ch.func       = FUNC_READ;
        acc_ch.reg_offset = OFF_CFG_LO;
        acc_ch.write_data = '0;
        acc_ch.pin_levels = '0;
        next_shuffle      = DIRECTED_CAP;
        port_locked_done  = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: reset values, pin level extremes, the output latch with
        // set winning over clear, write-only and reserved offsets, configuration
        // extremes, and lock key attempts that break off.
        directed_q.push_back(make_access(FUNC_READ,  OFF_CFG_LO, '0, '0));
        directed_q.push_back(make_access(FUNC_READ,  OFF_CFG_HI, '0, '0));
        directed_q.push_back(make_access(FUNC_READ,  OFF_INPUT,  '0, 16'hFFFF));
        directed_q.push_back(make_access(FUNC_READ,  OFF_INPUT,  '1, 16'h0000));
        directed_q.push_back(make_access(FUNC_WRITE, OFF_OUTPUT, '1, '0));
        directed_q.push_back(make_access(FUNC_WRITE, OFF_SETRST, '1, '0));
        directed_q.push_back(make_access(FUNC_WRITE, OFF_SETRST, 32'hFFFF_0000, '0));
        directed_q.push_back(make_access(FUNC_WRITE, OFF_SETRST, 32'h0000_A5A5, '1));
        directed_q.push_back(make_access(FUNC_READ,  OFF_OUTPUT, '0, '0));
        directed_q.push_back(make_access(FUNC_READ,  OFF_SETRST, '1, '1));
        directed_q.push_back(make_access(FUNC_WRITE, OFF_INPUT,  '1, '0));
        directed_q.push_back(make_access(FUNC_WRITE, 3'd5,       '1, '0));
        directed_q.push_back(make_access(FUNC_READ,  3'd5,       '0, '1));
        directed_q.push_back(make_access(FUNC_WRITE, 3'd7,       '1, '0));
        directed_q.push_back(make_access(FUNC_READ,  3'd7,       '0, '1));
        directed_q.push_back(make_access(FUNC_WRITE, OFF_CFG_LO, '1, '0));
        directed_q.push_back(make_access(FUNC_WRITE, OFF_CFG_HI, '0, '0));
        directed_q.push_back(make_access(FUNC_READ,  OFF_CFG_LO, '0, '0));
        directed_q.push_back(make_access(FUNC_READ,  OFF_CFG_HI, '0, '0));
        directed_q.push_back(make_lock_read());
        foreach (directed_q[i])
            send_word(directed_q[i]);
        drive_key_attempt(ATT_EARLY_READ);
        drive_key_attempt(ATT_CLEAR_FIRST);

        // Random part. Until the lock point the lock register only sees random writes
        // and attempts that break off, so its restart and idle rules get a thorough workout.
        // Then the key sequence is completed once, and the rest of the run checks
        // that locked configuration nibbles hold and lock writes are ignored.
        // The idling mix is redrawn every few dozen words and switched off for the
        // final stretch.
        while (words_sent < RUN_END) begin
            if (words_sent >= QUIET_START) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else if (words_sent >= next_shuffle) begin
                gap_odds     = idle_odds_pick();
                stall_odds   = idle_odds_pick();
                next_shuffle = next_shuffle + 64;
            end
            if (!port_locked_done && words_sent >= LOCK_POINT) begin
                drive_key_attempt(ATT_COMPLETE);
                port_locked_done = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                drive_key_attempt(t_attempt'($urandom_range(0, int'(ATT_COMPLETE) - 1)));
            end else begin
                send_word(random_access(port_locked_done ? LOCK_ANY : LOCK_WRITES));
            end
        end

        @(negedge i_clk);
        acc_ch.valid <= 1'b0;

        // Drain: every result word must come back, then a few quiet cycles catch
        // anything the port emits uninvited.
        while (pending_words != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (fail_count == 0 && pending_words == 0) begin
            $display("** gpio_port_registers_with_lock: PASSED **");
        end else begin
            $display("** gpio_port_registers_with_lock: FAILED **");
        end
        $finish;
    end

endmodule
